// ===== hdl/bwfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bwfpa_pkg
// Shared field widths, operation and status codes, and the control bundle
// that the sequencer hands to the page scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bwfpa_pkg;

    localparam int FUNC_W   = 2;
    localparam int OWNER_W  = 8;
    localparam int REQ_W    = 6;
    localparam int STATUS_W = 3;
    localparam int START_W  = 5;
    localparam int COUNT_W  = 6;
    localparam int FRAG_W   = 5;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FRAG  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RUNNING  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOFIT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD      = 3'd4;

    // clear: start of a pass, step: one page word is present,
    // last: the position past the final page, seen as an occupied page.
    typedef struct packed {
        logic clear;
        logic step;
        logic last;
    } t_scan_ctrl;

endpackage

`default_nettype wire

// ===== hdl/bwfpa_ram.sv =====
// ----------------------------------------------------------------------------
// bwfpa_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bwfpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/bwfpa_scan.sv =====
// ----------------------------------------------------------------------------
// bwfpa_scan
// Page scan unit. Takes one page owner word per step and keeps the free run
// tracker, the best or worst fitting run, owner presence, the owner hit count
// and the free run count for the current pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bwfpa_scan #(
    parameter int NUM_PAGES = 32,
    parameter int ID_BITS   = 8,
    localparam int CW = $clog2(NUM_PAGES + 1),
    localparam int AW = $clog2(NUM_PAGES),
    localparam int NW = (CW > bwfpa_pkg::REQ_W) ? CW : bwfpa_pkg::REQ_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire bwfpa_pkg::t_scan_ctrl i_ctrl,
    input  wire logic [ID_BITS-1:0]    i_owner,
    input  wire logic [AW-1:0]         i_addr,
    input  wire logic [ID_BITS-1:0]    i_id,
    input  wire logic [NW-1:0]         i_need,
    input  wire logic                  i_fit_mode,
    output logic                       o_hit,
    output logic                       o_present,
    output logic                       o_found,
    output logic      [AW-1:0]         o_best_start,
    output logic      [CW-1:0]         o_hit_count,
    output logic      [CW-1:0]         o_frag_count
);

    import bwfpa_pkg::*;

    logic [CW-1:0] r_run,       n_run;
    logic [AW-1:0] r_run_start, n_run_start;
    logic [CW-1:0] r_best_len,  n_best_len;
    logic [AW-1:0] r_best_start, n_best_start;
    logic          r_found,     n_found;
    logic          r_present,   n_present;
    logic [CW-1:0] r_hits,      n_hits;
    logic [CW-1:0] r_frags,     n_frags;

    logic is_free;
    logic close_run;
    logic take;

    assign is_free   = i_ctrl.step && (i_owner == '0);
    assign close_run = (i_ctrl.step || i_ctrl.last) && !is_free && (r_run != '0);
    assign o_hit     = i_ctrl.step && (i_owner == i_id);

    // The first fitting run is always taken; later ones only when strictly
    // larger (worst fit) or strictly smaller (best fit), so ties keep the first.
    always_comb begin
        if (!r_found) begin
            take = 1'b1;
        end else if (i_fit_mode) begin
            take = r_run > r_best_len;
        end else begin
            take = r_run < r_best_len;
        end
    end

    always_comb begin
        n_run        = r_run;
        n_run_start  = r_run_start;
        n_best_len   = r_best_len;
        n_best_start = r_best_start;
        n_found      = r_found;
        n_present    = r_present;
        n_hits       = r_hits;
        n_frags      = r_frags;
        if (i_ctrl.clear) begin
            n_run      = '0;
            n_best_len = '0;
            n_found    = 1'b0;
            n_present  = 1'b0;
            n_hits     = '0;
            n_frags    = '0;
        end else begin
            if (is_free) begin
                if (r_run == '0) begin
                    n_run_start = i_addr;
                    n_frags     = r_frags + CW'(1);
                end
                n_run = r_run + CW'(1);
            end else if (close_run) begin
                if ((NW'(r_run) >= i_need) && take) begin
                    n_found      = 1'b1;
                    n_best_len   = r_run;
                    n_best_start = r_run_start;
                end
                n_run = '0;
            end
            if (o_hit) begin
                n_present = 1'b1;
                n_hits    = r_hits + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= '0;
            r_found   <= 1'b0;
            r_present <= 1'b0;
            r_hits    <= '0;
            r_frags   <= '0;
        end else begin
            r_run     <= n_run;
            r_found   <= n_found;
            r_present <= n_present;
            r_hits    <= n_hits;
            r_frags   <= n_frags;
        end
        r_run_start  <= n_run_start;
        r_best_len   <= n_best_len;
        r_best_start <= n_best_start;
    end

    assign o_present    = r_present;
    assign o_found      = r_found;
    assign o_best_start = r_best_start;
    assign o_hit_count  = r_hits;
    assign o_frag_count = r_frags;

endmodule

`default_nettype wire

// ===== hdl/best_worst_fit_page_allocator.sv =====
// ----------------------------------------------------------------------------
// best_worst_fit_page_allocator
// Contiguous page allocator with best fit or worst fit placement, built as
// a sequencer around one page scan unit and a page owner RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the input channel (i_in_valid / o_in_ready) with
//   i_func, i_owner_id and i_request_pages; one result per request leaves on
//   the output channel (o_out_valid / i_out_ready). The fit policy is to be
//   written on the config channel (i_cfg_valid / o_cfg_ready, always ready)
//   only while idle; the user is bound by this, the block does not enforce it.
//   Every well-formed request walks the page owner RAM one page per cycle
//   through the scan unit, then passes S_DECIDE; a successful allocate then
//   writes its owner into every granted page in S_FILL. A malformed request
//   goes from S_IDLE straight to S_DONE. There is one RAM read port and a
//   single scan unit; one request is in flight at a time.
//   After reset the block clears the owner RAM, one page a cycle, with
//   o_in_ready low; config writes are taken meanwhile.
//   A finished result sits in the output register while the receiver stalls;
//   the block takes the next request then, and holds its result until the
//   output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module best_worst_fit_page_allocator #(
    parameter int NUM_PAGES = 32,
    parameter int ID_BITS   = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic                           i_cfg_fit_mode,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [bwfpa_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [bwfpa_pkg::OWNER_W-1:0]  i_owner_id,
    input  wire logic [bwfpa_pkg::REQ_W-1:0]    i_request_pages,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [bwfpa_pkg::STATUS_W-1:0] o_status,
    output logic      [bwfpa_pkg::START_W-1:0]  o_start_page,
    output logic      [bwfpa_pkg::COUNT_W-1:0]  o_page_count,
    output logic      [bwfpa_pkg::FRAG_W-1:0]   o_fragment_count
);

    import bwfpa_pkg::*;

    localparam int CW = $clog2(NUM_PAGES + 1);
    localparam int AW = $clog2(NUM_PAGES);
    localparam int NW = (CW > REQ_W) ? CW : REQ_W;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_FILL   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state              r_state,      n_state;
    logic [CW-1:0]       r_addr,       n_addr;
    logic                r_pend,       n_pend;
    logic [AW-1:0]       r_pend_addr,  n_pend_addr;
    logic [FUNC_W-1:0]   r_func,       n_func;
    logic [ID_BITS-1:0]  r_id,         n_id;
    logic [NW-1:0]       r_need,       n_need;
    logic [NW-1:0]       r_left,       n_left;
    logic                r_fit_mode;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [START_W-1:0]  r_res_start,  n_res_start;
    logic [COUNT_W-1:0]  r_res_count,  n_res_count;
    logic [FRAG_W-1:0]   r_res_frag,   n_res_frag;
    logic                r_out_valid,  n_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [START_W-1:0]  r_out_start;
    logic [COUNT_W-1:0]  r_out_count;
    logic [FRAG_W-1:0]   r_out_frag;

    logic               in_xfer;
    logic               out_load;
    logic [16:0]        id_wide;
    logic               id_ok;
    logic               req_bad;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ID_BITS-1:0] wr_data;
    logic [ID_BITS-1:0] rd_data;
    t_scan_ctrl         scan_ctrl;
    logic               scan_hit;
    logic               scan_present;
    logic               scan_found;
    logic [AW-1:0]      scan_best_start;
    logic [CW-1:0]      scan_hit_count;
    logic [CW-1:0]      scan_frag_count;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // An owner must be nonzero and fit in ID_BITS.
    assign id_wide = 17'(i_owner_id);
    assign id_ok   = (i_owner_id != '0) && ((id_wide >> ID_BITS) == '0);

    always_comb begin
        case (i_func)
            FUNC_ALLOC: req_bad = !id_ok || (i_request_pages == '0);
            FUNC_FREE:  req_bad = !id_ok;
            FUNC_FRAG:  req_bad = 1'b0;
            default:    req_bad = 1'b1;
        endcase
    end

    bwfpa_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (NUM_PAGES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    bwfpa_scan #(
        .NUM_PAGES (NUM_PAGES),
        .ID_BITS   (ID_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (scan_ctrl),
        .i_owner      (rd_data),
        .i_addr       (r_pend_addr),
        .i_id         (r_id),
        .i_need       (r_need),
        .i_fit_mode   (r_fit_mode),
        .o_hit        (scan_hit),
        .o_present    (scan_present),
        .o_found      (scan_found),
        .o_best_start (scan_best_start),
        .o_hit_count  (scan_hit_count),
        .o_frag_count (scan_frag_count)
    );

    always_comb begin
        scan_ctrl.clear = in_xfer && !req_bad;
        scan_ctrl.step  = (r_state == S_SCAN) && r_pend;
        scan_ctrl.last  = (r_state == S_SCAN) && !r_pend && (r_addr == CW'(NUM_PAGES));
    end

    // One write port serves the clearing pass, freeing and filling.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr[AW-1:0];
        wr_data = '0;
        case (r_state)
            S_CLEAR: wr_en = 1'b1;
            S_SCAN: begin
                wr_en   = (r_func == FUNC_FREE) && scan_hit;
                wr_addr = r_pend_addr;
            end
            S_FILL: begin
                wr_en   = 1'b1;
                wr_data = r_id;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_pend       = 1'b0;
        n_pend_addr  = r_pend_addr;
        n_func       = r_func;
        n_id         = r_id;
        n_need       = r_need;
        n_left       = r_left;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_res_count  = r_res_count;
        n_res_frag   = r_res_frag;
        case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + CW'(1);
                if (r_addr == CW'(NUM_PAGES - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_func       = i_func;
                    n_id         = ID_BITS'(i_owner_id);
                    n_need       = NW'(i_request_pages);
                    n_addr       = '0;
                    n_res_status = ST_OK;
                    n_res_start  = '0;
                    n_res_count  = '0;
                    n_res_frag   = '0;
                    if (req_bad) begin
                        n_res_status = ST_BAD;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Read data is registered in the RAM and comes back in the cycle after its address is issued.
                if (r_addr < CW'(NUM_PAGES)) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_addr[AW-1:0];
                    n_addr      = r_addr + CW'(1);
                end else if (!r_pend) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                case (r_func)
                    FUNC_ALLOC: begin
                        if (scan_present) begin
                            n_res_status = ST_RUNNING;
                        end else if (!scan_found) begin
                            n_res_status = ST_NOFIT;
                        end else begin
                            n_res_start = START_W'(scan_best_start);
                            n_res_count = COUNT_W'(r_need);
                            n_addr      = CW'(scan_best_start);
                            n_left      = r_need;
                            n_state     = S_FILL;
                        end
                    end
                    FUNC_FREE: begin
                        if (scan_hit_count == '0) begin
                            n_res_status = ST_NOTFOUND;
                        end else begin
                            n_res_count = COUNT_W'(scan_hit_count);
                        end
                    end
                    FUNC_FRAG: n_res_frag = FRAG_W'(scan_frag_count);
                    default:   n_res_status = ST_BAD;
                endcase
            end
            S_FILL: begin
                n_addr = r_addr + CW'(1);
                n_left = r_left - NW'(1);
                if (r_left == NW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_fit_mode  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fit_mode <= i_cfg_fit_mode;
            end
        end
        r_pend_addr  <= n_pend_addr;
        r_func       <= n_func;
        r_id         <= n_id;
        r_need       <= n_need;
        r_left       <= n_left;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_res_count  <= n_res_count;
        r_res_frag   <= n_res_frag;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_start  <= r_res_start;
            r_out_count  <= r_res_count;
            r_out_frag   <= r_res_frag;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_start_page     = r_out_start;
    assign o_page_count     = r_out_count;
    assign o_fragment_count = r_out_frag;

`ifndef NO_ASSERTIONS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !wr_en)
        else $error("owner RAM written outside a pass");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("request taken while a request is in flight");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_addr < CW'(NUM_PAGES)))
        else $error("fill ran past the last page");

    a_frag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> (scan_frag_count <= CW'((NUM_PAGES + 1) / 2)))
        else $error("free run count exceeds its bound");

    a_load_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid)
        else $error("result dropped at output load");
`endif

endmodule

`default_nettype wire

// ===== tb/best_worst_fit_page_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// best_worst_fit_page_allocator_tb
// Self-checking bench for the contiguous page allocator. A short table of
// directed requests covers the bad-request codes, the full and empty memory
// cases and the run at the end of memory; random phases follow, each under
// its own fit policy. A shadow page map in the bench predicts every result
// not typed into the table, and each result transfer is compared field by
// field with the oldest expectation.
// ----------------------------------------------------------------------------
module best_worst_fit_page_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bwfpa_pkg::*;

    localparam int NUM_PAGES     = 32;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 212;
    localparam int DIRECTED_ROWS = 25;

    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
    localparam logic FIT_BEST  = 1'b0;
    localparam logic FIT_WORST = 1'b1;

    localparam int RX_READY    = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_SPARSE   = 3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  start;
        logic [COUNT_W-1:0]  count;
        logic [FRAG_W-1:0]   frags;
    } t_result;

    // When fixed is set, res is the expectation typed into the table.
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [OWNER_W-1:0] owner;
        logic [REQ_W-1:0]   pages;
        logic               fixed;
        t_result            res;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_fit_mode;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [FUNC_W-1:0]   i_func;
    logic [OWNER_W-1:0]  i_owner_id;
    logic [REQ_W-1:0]    i_request_pages;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [STATUS_W-1:0] o_status;
    logic [START_W-1:0]  o_start_page;
    logic [COUNT_W-1:0]  o_page_count;
    logic [FRAG_W-1:0]   o_fragment_count;

    logic [OWNER_W-1:0] owner_of_page [NUM_PAGES];
    logic               fit_worst;

    t_row    pending_requests [$];
    t_result expected_results [$];

    int error_count;
    int requests_taken;
    int results_checked;
    int burst_left;
    int rx_mode;
    int rx_phase_left;
    int rx_tick;
    bit saw_best;
    bit saw_worst;

    t_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{FUNC_FRAG,    8'd0,   6'd0,  1'b1, '{ST_OK,       5'd0, 6'd0,  5'd1}},
        '{FUNC_ALLOC,   8'd0,   6'd5,  1'b1, '{ST_BAD,      5'd0, 6'd0,  5'd0}},
        '{FUNC_ALLOC,   8'd1,   6'd0,  1'b1, '{ST_BAD,      5'd0, 6'd0,  5'd0}},
        '{FUNC_UNKNOWN, 8'hFF,  6'h3F, 1'b1, '{ST_BAD,      5'd0, 6'd0,  5'd0}},
        '{FUNC_FREE,    8'd0,   6'd0,  1'b1, '{ST_BAD,      5'd0, 6'd0,  5'd0}},
        '{FUNC_FREE,    8'd7,   6'd0,  1'b1, '{ST_NOTFOUND, 5'd0, 6'd0,  5'd0}},
        '{FUNC_ALLOC,   8'd255, 6'd33, 1'b1, '{ST_NOFIT,    5'd0, 6'd0,  5'd0}},
        '{FUNC_ALLOC,   8'd255, 6'd63, 1'b1, '{ST_NOFIT,    5'd0, 6'd0,  5'd0}},
        '{FUNC_ALLOC,   8'd1,   6'd32, 1'b1, '{ST_OK,       5'd0, 6'd32, 5'd0}},
        '{FUNC_FRAG,    8'hA5,  6'h2A, 1'b1, '{ST_OK,       5'd0, 6'd0,  5'd0}},
        '{FUNC_ALLOC,   8'd1,   6'd1,  1'b1, '{ST_RUNNING,  5'd0, 6'd0,  5'd0}},
        '{FUNC_ALLOC,   8'd2,   6'd1,  1'b1, '{ST_NOFIT,    5'd0, 6'd0,  5'd0}},
        '{FUNC_FREE,    8'd1,   6'd0,  1'b1, '{ST_OK,       5'd0, 6'd32, 5'd0}},
        '{FUNC_ALLOC,   8'd10,  6'd4,  1'b1, '{ST_OK,       5'd0, 6'd4,  5'd0}},
        '{FUNC_ALLOC,   8'd11,  6'd3,  1'b1, '{ST_OK,       5'd4, 6'd3,  5'd0}},
        '{FUNC_ALLOC,   8'd12,  6'd6,  1'b0, '0},
        '{FUNC_ALLOC,   8'd13,  6'd2,  1'b0, '0},
        '{FUNC_FREE,    8'd11,  6'd9,  1'b0, '0},
        '{FUNC_FRAG,    8'd0,   6'd0,  1'b0, '0},
        '{FUNC_ALLOC,   8'd20,  6'd2,  1'b0, '0},
        '{FUNC_ALLOC,   8'd21,  6'd17, 1'b0, '0},
        '{FUNC_ALLOC,   8'd255, 6'd1,  1'b0, '0},
        '{FUNC_FRAG,    8'hFF,  6'h3F, 1'b0, '0},
        '{FUNC_FREE,    8'd255, 6'd0,  1'b0, '0},
        '{FUNC_FREE,    8'd2,   6'd0,  1'b0, '0}
    };

    best_worst_fit_page_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_fit_mode   (i_cfg_fit_mode),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_owner_id       (i_owner_id),
        .i_request_pages  (i_request_pages),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_start_page     (o_start_page),
        .o_page_count     (o_page_count),
        .o_fragment_count (o_fragment_count)
    );

    always #10 i_clk = ~i_clk;

    // Applies one request to the shadow page map and returns its result.
    function automatic t_result allocator_response(input logic [FUNC_W-1:0] func,
                                                   input logic [OWNER_W-1:0] owner,
                                                   input logic [REQ_W-1:0] pages);
        t_result r;
        int      run;
        int      run_start;
        int      best_len;
        int      best_start;
        int      tally;
        bit      found;
        bit      held;
        bit      is_free;
        bit      prev_free;
        bit      take;
        r = '0;
        run = 0;
        run_start = 0;
        best_len = 0;
        best_start = 0;
        tally = 0;
        found = 1'b0;
        held = 1'b0;
        prev_free = 1'b0;
        case (func)
            FUNC_ALLOC: begin
                for (int i = 0; i < NUM_PAGES; i++) begin
                    if (owner_of_page[i] == owner) held = 1'b1;
                end
                if (owner == '0 || pages == '0) begin
                    r.status = ST_BAD;
                end else if (held) begin
                    r.status = ST_RUNNING;
                end else if (pages > NUM_PAGES) begin
                    r.status = ST_NOFIT;
                end else begin
                    // The position past the last page closes a run at the end of memory.
                    for (int i = 0; i <= NUM_PAGES; i++) begin
                        is_free = 1'b0;
                        if (i < NUM_PAGES) is_free = (owner_of_page[i] == '0);
                        if (is_free) begin
                            if (run == 0) run_start = i;
                            run++;
                        end else if (run != 0) begin
                            if (run >= pages) begin
                                if (!found) take = 1'b1;
                                else if (fit_worst) take = run > best_len;
                                else take = run < best_len;
                                if (take) begin
                                    found = 1'b1;
                                    best_len = run;
                                    best_start = run_start;
                                end
                            end
                            run = 0;
                        end
                    end
                    if (!found) begin
                        r.status = ST_NOFIT;
                    end else begin
                        for (int i = best_start; i < best_start + pages; i++) begin
                            owner_of_page[i] = owner;
                        end
                        r.status = ST_OK;
                        r.start = best_start[START_W-1:0];
                        r.count = pages;
                    end
                end
            end
            FUNC_FREE: begin
                if (owner == '0) begin
                    r.status = ST_BAD;
                end else begin
                    for (int i = 0; i < NUM_PAGES; i++) begin
                        if (owner_of_page[i] == owner) begin
                            owner_of_page[i] = '0;
                            tally++;
                        end
                    end
                    r.status = (tally == 0) ? ST_NOTFOUND : ST_OK;
                    r.count = tally[COUNT_W-1:0];
                end
            end
            FUNC_FRAG: begin
                for (int i = 0; i < NUM_PAGES; i++) begin
                    is_free = (owner_of_page[i] == '0);
                    if (is_free && !prev_free) tally++;
                    prev_free = is_free;
                end
                r.status = ST_OK;
                r.frags = tally[FRAG_W-1:0];
            end
            default: begin
                r.status = ST_BAD;
            end
        endcase
        return r;
    endfunction

    // Mostly well-formed traffic over a small owner pool, so that memory
    // fills, fragments and drains; the rest is malformed noise.
    function automatic t_row random_request();
        t_row row;
        int   pick;
        int   kind;
        row = '0;
        pick = $urandom_range(0, 15);
        row.owner = (pick < 12) ? OWNER_W'(pick + 1) : OWNER_W'(8'hF0 + pick);
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            row.func = FUNC_ALLOC;
            pick = $urandom_range(0, 19);
            if (pick < 15) row.pages = REQ_W'($urandom_range(1, 6));
            else if (pick < 19) row.pages = REQ_W'($urandom_range(7, 16));
            else row.pages = REQ_W'($urandom_range(17, 32));
        end else if (kind < 80) begin
            row.func = FUNC_FREE;
            row.pages = REQ_W'($urandom_range(0, 63));
        end else if (kind < 90) begin
            row.func = FUNC_FRAG;
            row.owner = OWNER_W'($urandom_range(0, 255));
            row.pages = REQ_W'($urandom_range(0, 63));
        end else begin
            row.func = FUNC_W'($urandom_range(0, 3));
            row.owner = ($urandom_range(0, 3) == 0) ? '0 : OWNER_W'($urandom_range(0, 255));
            pick = $urandom_range(0, 2);
            if (pick == 0) row.pages = '0;
            else if (pick == 1) row.pages = REQ_W'($urandom_range(33, 63));
            else row.pages = REQ_W'($urandom_range(0, 63));
        end
        return row;
    endfunction

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected, actual);
            error_count++;
        end
    endtask

    task automatic write_fit_mode(input logic mode);
        i_cfg_valid <= 1'b1;
        i_cfg_fit_mode <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Valid stays high across a burst; a gap follows each burst.
    task automatic send_request(input t_row row);
        pending_requests.push_back(row);
        i_in_valid <= 1'b1;
        i_func <= row.func;
        i_owner_id <= row.owner;
        i_request_pages <= row.pages;
        do @(posedge i_clk); while (!o_in_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge i_clk);
            burst_left = $urandom_range(0, 11);
        end
    endtask

    task automatic wait_drain();
        while (pending_requests.size() != 0 || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Prediction at each request transfer, checking at each result transfer.
    always @(posedge i_clk) begin
        t_row    row;
        t_result seen;
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                fit_worst = i_cfg_fit_mode;
                if (i_cfg_fit_mode == FIT_WORST) saw_worst = 1'b1;
                else saw_best = 1'b1;
            end
            if (i_in_valid && o_in_ready) begin
                row = '0;
                if (pending_requests.size() != 0) row = pending_requests.pop_front();
                want = allocator_response(i_func, i_owner_id, i_request_pages);
                expected_results.push_back(row.fixed ? row.res : want);
                requests_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result transfer with no request outstanding", $time);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    seen = '{o_status, o_start_page, o_page_count, o_fragment_count};
                    check_field("status", want.status, seen.status);
                    check_field("start_page", want.start, seen.start);
                    check_field("page_count", want.count, seen.count);
                    check_field("fragment_count", want.frags, seen.frags);
                    results_checked++;
                end
            end
        end
    end

    // The receiver switches at random between stall patterns.
    always @(posedge i_clk) begin
        if (rx_phase_left == 0) begin
            rx_mode = $urandom_range(RX_READY, RX_SPARSE);
            rx_phase_left = $urandom_range(50, 400);
        end
        rx_phase_left--;
        rx_tick++;
        case (rx_mode)
            RX_READY:    i_out_ready <= 1'b1;
            RX_RANDOM:   i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: i_out_ready <= (rx_tick % 5 == 0);
            default:     i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic phase_mode;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_fit_mode = FIT_BEST;
        i_in_valid = 1'b0;
        i_func = FUNC_FRAG;
        i_owner_id = '0;
        i_request_pages = '0;
        i_out_ready = 1'b0;
        fit_worst = FIT_BEST;
        error_count = 0;
        requests_taken = 0;
        results_checked = 0;
        burst_left = 0;
        rx_mode = RX_READY;
        rx_phase_left = 0;
        rx_tick = 0;
        saw_best = 1'b0;
        saw_worst = 1'b0;
        for (int i = 0; i < NUM_PAGES; i++) owner_of_page[i] = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_fit_mode(FIT_BEST);
        for (int i = 0; i < DIRECTED_ROWS; i++) send_request(directed_rows[i]);
        i_in_valid <= 1'b0;
        wait_drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) phase_mode = FIT_WORST;
            else if (p == 1) phase_mode = FIT_BEST;
            else phase_mode = logic'($urandom_range(0, 1));
            write_fit_mode(phase_mode);
            for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
            i_in_valid <= 1'b0;
            wait_drain();
        end

        repeat (NUM_PAGES + 48) @(posedge i_clk);
        $display("Covered %0d requests and %0d checked results over %0d phases.",
                 requests_taken, results_checked, RANDOM_PHASES + 1);
        $display("Fit policies exercised: best fit %0d, worst fit %0d.", saw_best, saw_worst);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
